### hw/rtl/touch_report_decoder_defines.svh
// Assertion macros for the touch report decoder checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef TOUCH_REPORT_DECODER_DEFINES_SVH
`define TOUCH_REPORT_DECODER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define TRD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/trd_pkg.sv
// Shared types and constants for the touch report decoder.
// No dependencies; imported by every other file of the block but the macro header.
`default_nettype none

package trd_pkg;

  localparam int COORD_W    = 16;
  localparam int PROD_W     = 2 * COORD_W;
  localparam int ID_W       = 8;
  localparam int STATUS_W   = 8;
  localparam int COUNT_W    = 4;
  localparam int EMIT_W     = 3;
  localparam int ROT_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int DIV_STEPS = PROD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int STATUS_READY_BIT = 7;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_POINT  = 1'b1;

  localparam logic [EMIT_W-1:0] MAX_POINTS_RST = 3'd5;
  localparam logic [COORD_W-1:0] COORD_SAT     = 16'hFFFF;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_MAX_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_MAX_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_POINTS    = 3'd5;

  // quarter turns
  localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
  localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
  localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
  localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

  typedef enum logic [2:0] {
    RC_NOT_READY,
    RC_BAD_COUNT,
    RC_REPORT_START,
    RC_POINT,
    RC_SUPPRESSED,
    RC_UNEXPECTED
  } res_code_t;

  typedef struct packed {
    logic                kind;
    logic [STATUS_W-1:0] status_byte;
    logic [COORD_W-1:0]  raw_x;
    logic [COORD_W-1:0]  raw_y;
    logic [COORD_W-1:0]  raw_size;
    logic [ID_W-1:0]     track_id;
  } in_item_t;

  typedef struct packed {
    res_code_t          result_code;
    logic [EMIT_W-1:0]  point_count;
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic [COORD_W-1:0] point_size;
    logic [ID_W-1:0]    point_id;
    logic               clear_status;
    logic               last_point;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic              capture;
    logic              mul;
    logic              div_start;
    logic              load_out;
    res_code_t         code;
    logic [EMIT_W-1:0] point_count;
    logic              clear_status;
    logic              last_point;
  } trd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic              div_done;
    logic              out_free;
    logic [EMIT_W-1:0] max_points;
  } trd_sts_t;

endpackage

`default_nettype wire

### hw/rtl/trd_if.sv
// Channel interfaces of the touch report decoder: input, result, config.
// Depends on trd_pkg for payload types.
`default_nettype none

interface trd_in_if import trd_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface trd_out_if import trd_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface trd_cfg_if import trd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/trd_div.sv
// Restoring divider, one quotient bit per cycle, 32 by 16 bits.
// Depends on trd_pkg for widths.
`default_nettype none

module trd_div import trd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [PROD_W-1:0]  dividend,
  input  wire logic [COORD_W-1:0] divisor,
  output logic                    done,
  output logic [PROD_W-1:0]       quotient
);

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  logic                 run_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [PROD_W-1:0]    quo_r;
  logic [COORD_W-1:0]   rem_r;

  logic [COORD_W:0]     shifted;
  logic [COORD_W:0]     diff;
  logic                 ge;
  logic [COORD_W-1:0]   rem_nxt;
  logic [PROD_W-1:0]    quo_nxt;

  // remainder stays below the divisor, so the shifted value fits one extra bit
  assign shifted = {rem_r, quo_r[PROD_W-1]};
  assign diff    = shifted - {1'b0, divisor};
  assign ge      = shifted >= {1'b0, divisor};
  assign rem_nxt = ge ? diff[COORD_W-1:0] : shifted[COORD_W-1:0];
  assign quo_nxt = {quo_r[PROD_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (run_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

### hw/rtl/trd_dp.sv
// Datapath: config registers, input capture, multipliers, two dividers,
// rotation and the result register. Depends on trd_pkg and trd_div.
`default_nettype none

module trd_dp import trd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire in_item_t              in_item,
  input  wire trd_cmd_t              cmd,
  output trd_sts_t                   sts,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output out_item_t                  out_item
);

  logic [COORD_W-1:0] sensor_max_x_r;
  logic [COORD_W-1:0] sensor_max_y_r;
  logic [COORD_W-1:0] screen_width_r;
  logic [COORD_W-1:0] screen_height_r;
  logic [ROT_W-1:0]   rotation_r;
  logic [EMIT_W-1:0]  max_points_r;

  logic [COORD_W-1:0] raw_x_r;
  logic [COORD_W-1:0] raw_y_r;
  logic [COORD_W-1:0] raw_size_r;
  logic [ID_W-1:0]    track_id_r;

  logic [PROD_W-1:0]  prod_x_r;
  logic [PROD_W-1:0]  prod_y_r;
  logic [PROD_W-1:0]  prod_x_nxt;
  logic [PROD_W-1:0]  prod_y_nxt;

  logic               out_valid_r;
  out_item_t          out_item_r;
  out_item_t          out_item_nxt;

  logic               done_x;
  logic               done_y;
  logic [PROD_W-1:0]  quo_x;
  logic [PROD_W-1:0]  quo_y;

  logic [COORD_W-1:0] map_x;
  logic [COORD_W-1:0] map_y;
  logic [COORD_W-1:0] rot_x;
  logic [COORD_W-1:0] rot_y;

  function automatic logic [COORD_W-1:0] sat_map(input logic [PROD_W-1:0]  q,
                                                 input logic [COORD_W-1:0] smax);
    logic [COORD_W-1:0] res;
    if (smax == '0) begin
      res = '0;
    end else if (|q[PROD_W-1:COORD_W]) begin
      res = COORD_SAT;
    end else begin
      res = q[COORD_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [COORD_W-1:0] floor_sub(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
    logic [COORD_W-1:0] res;
    res = (b > a) ? '0 : a - b;
    return res;
  endfunction

  assign prod_x_nxt = PROD_W'(raw_x_r) * PROD_W'(screen_width_r);
  assign prod_y_nxt = PROD_W'(raw_y_r) * PROD_W'(screen_height_r);

  trd_div u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_x_r),
    .divisor  (sensor_max_x_r),
    .done     (done_x),
    .quotient (quo_x)
  );

  trd_div u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_y_r),
    .divisor  (sensor_max_y_r),
    .done     (done_y),
    .quotient (quo_y)
  );

  assign map_x = sat_map(quo_x, sensor_max_x_r);
  assign map_y = sat_map(quo_y, sensor_max_y_r);

  always_comb begin
    unique case (rotation_r)
      ROT_90: begin
        rot_x = map_y;
        rot_y = floor_sub(screen_width_r, map_x);
      end
      ROT_180: begin
        rot_x = floor_sub(screen_width_r, map_x);
        rot_y = floor_sub(screen_height_r, map_y);
      end
      ROT_270: begin
        rot_x = floor_sub(screen_height_r, map_y);
        rot_y = map_x;
      end
      default: begin
        rot_x = map_x;
        rot_y = map_y;
      end
    endcase
  end

  always_comb begin
    out_item_nxt              = '0;
    out_item_nxt.result_code  = cmd.code;
    out_item_nxt.point_count  = cmd.point_count;
    out_item_nxt.clear_status = cmd.clear_status;
    out_item_nxt.last_point   = cmd.last_point;
    if (cmd.code == RC_POINT) begin
      out_item_nxt.point_x    = rot_x;
      out_item_nxt.point_y    = rot_y;
      out_item_nxt.point_size = raw_size_r;
      out_item_nxt.point_id   = track_id_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_max_x_r  <= '0;
      sensor_max_y_r  <= '0;
      screen_width_r  <= '0;
      screen_height_r <= '0;
      rotation_r      <= ROT_0;
      max_points_r    <= MAX_POINTS_RST;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SENSOR_MAX_X:  sensor_max_x_r  <= cfg_data;
          REG_SENSOR_MAX_Y:  sensor_max_y_r  <= cfg_data;
          REG_SCREEN_WIDTH:  screen_width_r  <= cfg_data;
          REG_SCREEN_HEIGHT: screen_height_r <= cfg_data;
          REG_ROTATION:      rotation_r      <= cfg_data[ROT_W-1:0];
          REG_MAX_POINTS:    max_points_r    <= cfg_data[EMIT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      raw_x_r    <= in_item.raw_x;
      raw_y_r    <= in_item.raw_y;
      raw_size_r <= in_item.raw_size;
      track_id_r <= in_item.track_id;
    end
    if (cmd.mul) begin
      prod_x_r <= prod_x_nxt;
      prod_y_r <= prod_y_nxt;
    end
    if (cmd.load_out) begin
      out_item_r <= out_item_nxt;
    end
  end

  // both dividers start together and take the same number of steps
  assign sts.div_done   = done_x & done_y;
  assign sts.out_free   = ~out_valid_r | out_ready;
  assign sts.max_points = max_points_r;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

### hw/rtl/trd_ctrl.sv
// Controller: report state (records and emits left) and the sequencer
// that steps one item through the datapath. Depends on trd_pkg.
`default_nettype none

module trd_ctrl import trd_pkg::*; #(
  parameter int MAX_TOUCH = 5
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_kind,
  input  wire logic [STATUS_W-1:0] in_status,
  output logic                     in_ready,
  input  wire trd_sts_t            sts,
  output trd_cmd_t                 cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DSTART,
    S_DIV,
    S_FIN
  } state_t;

  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_TOUCH);

  state_t             state_r, state_nxt;
  logic [COUNT_W-1:0] records_left_r, records_left_nxt;
  logic [EMIT_W-1:0]  emits_left_r, emits_left_nxt;
  logic               report_open_r, report_open_nxt;
  res_code_t          code_r, code_nxt;
  logic [EMIT_W-1:0]  count_r, count_nxt;
  logic               clear_r, clear_nxt;
  logic               last_r, last_nxt;

  logic [COUNT_W-1:0] status_count;
  logic [EMIT_W-1:0]  emit_n;

  assign status_count = in_status[COUNT_W-1:0];
  assign emit_n = (status_count < {1'b0, sts.max_points}) ? status_count[EMIT_W-1:0]
                                                          : sts.max_points;

  always_comb begin
    state_nxt        = state_r;
    records_left_nxt = records_left_r;
    emits_left_nxt   = emits_left_r;
    report_open_nxt  = report_open_r;
    code_nxt         = code_r;
    count_nxt        = count_r;
    clear_nxt        = clear_r;
    last_nxt         = last_r;
    in_ready         = 1'b0;

    cmd              = '0;
    cmd.code         = code_r;
    cmd.point_count  = count_r;
    cmd.clear_status = clear_r;
    cmd.last_point   = last_r;

    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          count_nxt = '0;
          clear_nxt = 1'b0;
          last_nxt  = 1'b0;
          state_nxt = S_FIN;
          if (in_kind == KIND_STATUS) begin
            // any status item closes the open report first
            report_open_nxt  = 1'b0;
            records_left_nxt = '0;
            emits_left_nxt   = '0;
            if (!in_status[STATUS_READY_BIT]) begin
              code_nxt = RC_NOT_READY;
            end else if (status_count == '0 || status_count > MAX_COUNT) begin
              code_nxt  = RC_BAD_COUNT;
              clear_nxt = 1'b1;
            end else begin
              report_open_nxt  = 1'b1;
              records_left_nxt = status_count;
              emits_left_nxt   = emit_n;
              code_nxt         = RC_REPORT_START;
              count_nxt        = emit_n;
            end
          end else if (!report_open_r || records_left_r == '0) begin
            code_nxt = RC_UNEXPECTED;
          end else begin
            records_left_nxt = records_left_r - COUNT_W'(1);
            if (emits_left_r != '0) begin
              code_nxt       = RC_POINT;
              emits_left_nxt = emits_left_r - EMIT_W'(1);
              state_nxt      = S_MUL;
            end else begin
              code_nxt = RC_SUPPRESSED;
            end
            if (records_left_r == COUNT_W'(1)) begin
              clear_nxt       = 1'b1;
              last_nxt        = 1'b1;
              report_open_nxt = 1'b0;
              emits_left_nxt  = '0;
            end
          end
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.load_out = sts.out_free;
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      records_left_r <= '0;
      emits_left_r   <= '0;
      report_open_r  <= 1'b0;
      code_r         <= RC_NOT_READY;
      count_r        <= '0;
      clear_r        <= 1'b0;
      last_r         <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      records_left_r <= records_left_nxt;
      emits_left_r   <= emits_left_nxt;
      report_open_r  <= report_open_nxt;
      code_r         <= code_nxt;
      count_r        <= count_nxt;
      clear_r        <= clear_nxt;
      last_r         <= last_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/touch_report_decoder.sv
// Top level of the touch report decoder: joins controller and datapath.
// Depends on trd_pkg, trd_if, trd_ctrl, trd_dp (and trd_div below it).
//
//  channel  direction  handshake              payload
//  in_if    sink       valid/ready transfer   in_item_t (status or point record)
//  out_if   source     valid/ready transfer   out_item_t (one result per item)
//  cfg_if   sink       valid/ready transfer   3-bit index, 16-bit data
//
// Status items, suppressed and unexpected records go from accept straight to finish.
// Emitted point records go through accept, multiply, divider start, the
// 32-step restoring dividers (x and y run side by side), done and finish.
// The result register frees the input side: the next item is taken while a
// result waits, and only the finish step stalls on a full result register.
// Reset is synchronous, active low; config comes back to its reset values
// and any open report is dropped. cfg_if.ready is tied high.
`default_nettype none

module touch_report_decoder import trd_pkg::*; #(
  parameter int MAX_TOUCH = 5
) (
  input  wire logic clk,
  input  wire logic rst_n,
  trd_in_if.sink    in_if,
  trd_out_if.source out_if,
  trd_cfg_if.sink   cfg_if
);

  trd_cmd_t cmd;
  trd_sts_t sts;
  logic     cfg_we;

  // config transfers are taken at once; the sender must write only while idle; the block does not enforce it
  assign cfg_if.ready = 1'b1;
  assign cfg_we       = cfg_if.valid;

  trd_ctrl #(
    .MAX_TOUCH (MAX_TOUCH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_kind   (in_if.item.kind),
    .in_status (in_if.item.status_byte),
    .in_ready  (in_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  trd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_if.index),
    .cfg_data  (cfg_if.data),
    .in_item   (in_if.item),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_if.ready),
    .out_valid (out_if.valid),
    .out_item  (out_if.item)
  );

endmodule

`default_nettype wire

### hw/rtl/trd_chk.sv
// Port-level checker for the touch report decoder, bound to the top level.
// Depends on trd_pkg and touch_report_decoder_defines.svh.
`default_nettype none
`include "touch_report_decoder_defines.svh"

module trd_chk import trd_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_item
);

  `TRD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "result changed while stalled")
  `TRD_ASSERT_SAME(a_pt_zero, out_valid && out_item.result_code != RC_POINT, out_item.point_x == '0 && out_item.point_y == '0 && out_item.point_size == '0 && out_item.point_id == '0, "point fields set on a non-point result")
  `TRD_ASSERT_SAME(a_last, out_valid && out_item.last_point, out_item.clear_status && (out_item.result_code == RC_POINT || out_item.result_code == RC_SUPPRESSED), "last record without clear or on wrong code")
  `TRD_ASSERT_SAME(a_count, out_valid && out_item.result_code != RC_REPORT_START, out_item.point_count == '0, "point count outside report start")
  `TRD_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "second item taken while one is in flight")

endmodule

bind touch_report_decoder trd_chk u_trd_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_item  (out_if.item)
);

`default_nettype wire
